[src/rtdt_pkg.sv]
package rtdt_pkg;

    localparam logic [1:0] ACT_SLOT = 2'd0;
    localparam logic [1:0] ACT_KIND = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;
    localparam logic [1:0] ACT_END  = 2'd3;

    localparam logic [2:0] OP_SLOT = 3'd0;
    localparam logic [2:0] OP_KIND = 3'd1;
    localparam logic [2:0] OP_BYTE = 3'd2;
    localparam logic [2:0] OP_END  = 3'd3;
    localparam logic [2:0] OP_SKIP = 3'd4;

    localparam logic [1:0] STAT_VALID  = 2'd0;
    localparam logic [1:0] STAT_ACCEND = 2'd1;
    localparam logic [1:0] STAT_NONACC = 2'd2;
    localparam logic [1:0] STAT_BAD    = 2'd3;

    localparam logic signed [10:0] KIND_NONE = -11'sd1;
    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic              valid;
        logic [5:0]        target;
        logic signed [7:0] high;
        logic signed [7:0] low;
    } tr_entry_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [5:0]         node;
        logic [2:0]         slot;
        tr_entry_t          entry;
        logic signed [10:0] kind;
        logic signed [7:0]  char_in;
    } item_t;

    typedef struct packed {
        logic signed [10:0] kind;
        logic [7:0]         len;
        logic [15:0]        line;
        logic [15:0]        col;
        logic [1:0]         status;
    } result_t;

endpackage

[src/rtdt_front.sv]
module rtdt_front #(
    parameter int NODES = 64,
    parameter int SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [55:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               item_valid,
    output rtdt_pkg::item_t    item,
    input  logic               item_pop
);

    rtdt_pkg::item_t q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    rtdt_pkg::item_t cls;
    logic signed [7:0] a;
    logic signed [7:0] b;
    logic [5:0] f_node;
    logic [2:0] f_slot;
    logic [5:0] f_target;
    logic push;

    assign f_node   = s_tdata[5:0];
    assign f_slot   = s_tdata[8:6];
    assign a        = s_tdata[16:9];
    assign b        = s_tdata[24:17];
    assign f_target = s_tdata[30:25];

    // classify: order the range ends and drop out-of-range table writes
    always_comb begin
        cls              = '0;
        cls.node         = f_node;
        cls.slot         = f_slot;
        cls.entry.low    = (a < b) ? a : b;
        cls.entry.high   = (a < b) ? b : a;
        cls.entry.target = f_target;
        cls.entry.valid  = s_tdata[31];
        cls.kind         = s_tdata[42:32];
        cls.char_in      = s_tdata[50:43];
        unique case (s_tuser)
            rtdt_pkg::ACT_SLOT: begin
                cls.op = (32'(f_node) < NODES && 32'(f_slot) < SLOTS && 32'(f_target) < NODES)
                       ? rtdt_pkg::OP_SLOT : rtdt_pkg::OP_SKIP;
            end
            rtdt_pkg::ACT_KIND: begin
                cls.op = (32'(f_node) < NODES) ? rtdt_pkg::OP_KIND : rtdt_pkg::OP_SKIP;
            end
            rtdt_pkg::ACT_BYTE: cls.op = rtdt_pkg::OP_BYTE;
            rtdt_pkg::ACT_END:  cls.op = rtdt_pkg::OP_END;
            default:            cls.op = rtdt_pkg::OP_SKIP;
        endcase
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (item_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(item_pop);
        end
    end

endmodule

[src/rtdt_back.sv]
module rtdt_back #(
    parameter int NODES      = 64,
    parameter int SLOTS      = 8,
    parameter int MAX_LEXEME = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rep_in,
    input  logic               item_valid,
    input  rtdt_pkg::item_t    item,
    output logic               item_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output rtdt_pkg::result_t  res,
    output logic               res_last
);

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(MAX_LEXEME + 1);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MATCH = 3'd2;
    localparam logic [2:0] ST_KIND  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    rtdt_pkg::tr_entry_t tr_mem [NODES][SLOTS];
    logic signed [10:0]  kind_mem [NODES];
    rtdt_pkg::tr_entry_t row_cur_q [SLOTS];
    rtdt_pkg::tr_entry_t row_zero_q [SLOTS];
    logic signed [10:0]  kind_q;

    logic [2:0]    state_reg;
    logic [NW-1:0] clr_idx_reg;
    logic [NW-1:0] cur_reg;
    logic [LW-1:0] pend_reg;
    logic [15:0]   line_reg;
    logic [15:0]   col_reg;
    logic [1:0]    run_reg;
    logic signed [7:0] char_reg;
    logic          is_end_reg;
    logic          nul_hit_reg;
    logic          n_reg;
    logic          cnt_reg;
    logic          idx_reg;
    rtdt_pkg::result_t res_reg [2];
    rtdt_pkg::result_t out_reg;
    logic          out_valid_reg;
    logic          out_last_reg;

    logic          start;
    logic [NW-1:0] kind_addr;
    logic          hit_cur;
    logic          hit_zero;
    logic [5:0]    tgt_cur;
    logic [5:0]    tgt_zero;
    logic signed [7:0] c_zero;
    logic [LW-1:0] pend_inc;
    logic [15:0]   line_inc;
    logic [15:0]   col_inc;
    logic [7:0]    len_out;
    logic          had;
    logic          ok;
    logic          stopped;
    logic          out_load;
    rtdt_pkg::result_t flush_res;
    rtdt_pkg::result_t fail_res;

    assign start    = (state_reg == ST_IDLE) && item_valid;
    assign item_pop = start;
    assign stopped  = !rep_in && (run_reg != rtdt_pkg::STAT_VALID);
    assign kind_addr = (state_reg == ST_MATCH) ? NW'(tgt_zero) : cur_reg;
    assign c_zero   = is_end_reg ? $signed(rtdt_pkg::CHAR_NUL) : char_reg;

    // priority match, lowest slot wins
    always_comb begin
        hit_cur  = 1'b0;
        hit_zero = 1'b0;
        tgt_cur  = '0;
        tgt_zero = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (row_cur_q[s].valid && row_cur_q[s].low <= char_reg
                && char_reg <= row_cur_q[s].high) begin
                hit_cur = 1'b1;
                tgt_cur = row_cur_q[s].target;
            end
            if (row_zero_q[s].valid && row_zero_q[s].low <= c_zero
                && c_zero <= row_zero_q[s].high) begin
                hit_zero = 1'b1;
                tgt_zero = row_zero_q[s].target;
            end
        end
    end

    always_comb begin
        pend_inc = (32'(pend_reg) < MAX_LEXEME) ? pend_reg + LW'(1) : pend_reg;
        if (char_reg == $signed(rtdt_pkg::CHAR_NL)) begin
            line_inc = (line_reg != rtdt_pkg::CNT_MAX) ? line_reg + 16'd1 : line_reg;
            col_inc  = 16'd1;
        end else begin
            line_inc = line_reg;
            col_inc  = (col_reg != rtdt_pkg::CNT_MAX) ? col_reg + 16'd1 : col_reg;
        end
        len_out = (32'(pend_reg) > 255) ? 8'hFF : 8'(pend_reg);
        had = (pend_reg != '0);
        ok  = had && !kind_q[10];
        flush_res.kind   = ok ? kind_q : rtdt_pkg::KIND_NONE;
        flush_res.len    = len_out;
        flush_res.line   = line_reg;
        flush_res.col    = col_reg;
        flush_res.status = ok ? rtdt_pkg::STAT_VALID : rtdt_pkg::STAT_NONACC;
        fail_res.kind    = rtdt_pkg::KIND_NONE;
        fail_res.len     = 8'd0;
        fail_res.line    = line_reg;
        fail_res.col     = col_reg;
        fail_res.status  = rtdt_pkg::STAT_NONACC;
    end

    // table storage, rows read whole
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLR) begin
            for (int s = 0; s < SLOTS; s++) begin
                tr_mem[clr_idx_reg][s] <= '0;
            end
            kind_mem[clr_idx_reg] <= rtdt_pkg::KIND_NONE;
        end else if (start && item.op == rtdt_pkg::OP_SLOT) begin
            tr_mem[NW'(item.node)][SW'(item.slot)] <= item.entry;
        end else if (start && item.op == rtdt_pkg::OP_KIND) begin
            kind_mem[NW'(item.node)] <= item.kind;
        end
        row_cur_q  <= tr_mem[cur_reg];
        row_zero_q <= tr_mem[0];
        kind_q     <= kind_mem[kind_addr];
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || res_ready);

    always_ff @(posedge aclk) begin
        if (start) begin
            char_reg   <= item.char_in;
            is_end_reg <= (item.op == rtdt_pkg::OP_END);
        end
        if (out_load) begin
            out_reg      <= res_reg[idx_reg];
            out_last_reg <= (idx_reg == cnt_reg);
        end
        if (start && stopped) begin
            res_reg[0] <= '{kind: rtdt_pkg::KIND_NONE, len: 8'd0, line: line_reg,
                            col: col_reg,
                            status: (run_reg == rtdt_pkg::STAT_ACCEND)
                                  ? rtdt_pkg::STAT_ACCEND : rtdt_pkg::STAT_BAD};
        end
        if (state_reg == ST_MATCH) begin
            res_reg[0] <= flush_res;
            res_reg[1] <= fail_res;
        end
        if (state_reg == ST_KIND) begin
            res_reg[n_reg] <= nul_hit_reg
                ? '{kind: kind_q, len: 8'd0, line: line_reg, col: col_reg,
                    status: rtdt_pkg::STAT_ACCEND}
                : fail_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            clr_idx_reg   <= '0;
            cur_reg       <= '0;
            pend_reg      <= '0;
            line_reg      <= 16'd1;
            col_reg       <= 16'd1;
            run_reg       <= rtdt_pkg::STAT_VALID;
            nul_hit_reg   <= 1'b0;
            n_reg         <= 1'b0;
            cnt_reg       <= 1'b0;
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && res_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR: begin
                    clr_idx_reg <= clr_idx_reg + NW'(1);
                    if (32'(clr_idx_reg) == NODES - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start && (item.op == rtdt_pkg::OP_BYTE
                                  || item.op == rtdt_pkg::OP_END)) begin
                        if (stopped) begin
                            if (run_reg != rtdt_pkg::STAT_ACCEND) begin
                                run_reg <= rtdt_pkg::STAT_BAD;
                            end
                            cnt_reg   <= 1'b0;
                            idx_reg   <= 1'b0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MATCH;
                        end
                    end
                end
                ST_MATCH: begin
                    idx_reg <= 1'b0;
                    if (!is_end_reg) begin
                        if (hit_cur) begin
                            cur_reg   <= NW'(tgt_cur);
                            pend_reg  <= pend_inc;
                            line_reg  <= line_inc;
                            col_reg   <= col_inc;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_OUT;
                            if (had && (ok || rep_in) && hit_zero) begin
                                // retry from node 0 consumes the byte
                                run_reg  <= ok ? rtdt_pkg::STAT_VALID : rtdt_pkg::STAT_NONACC;
                                cur_reg  <= NW'(tgt_zero);
                                pend_reg <= LW'(1);
                                line_reg <= line_inc;
                                col_reg  <= col_inc;
                                cnt_reg  <= 1'b0;
                            end else begin
                                run_reg  <= rtdt_pkg::STAT_NONACC;
                                cur_reg  <= '0;
                                pend_reg <= '0;
                                cnt_reg  <= had && (ok || rep_in);
                            end
                        end
                    end else begin
                        cur_reg     <= '0;
                        pend_reg    <= '0;
                        nul_hit_reg <= hit_zero;
                        n_reg       <= had;
                        if (had) begin
                            run_reg <= ok ? rtdt_pkg::STAT_VALID : rtdt_pkg::STAT_NONACC;
                        end
                        if (had && !ok && !rep_in) begin
                            cnt_reg   <= 1'b0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_KIND;
                        end
                    end
                end
                ST_KIND: begin
                    run_reg   <= nul_hit_reg ? rtdt_pkg::STAT_ACCEND : rtdt_pkg::STAT_NONACC;
                    cnt_reg   <= n_reg;
                    idx_reg   <= 1'b0;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_valid_reg <= 1'b1;
                        if (idx_reg == cnt_reg) begin
                            idx_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign res_last  = out_last_reg;

endmodule

[src/range_table_dfa_tokenizer.sv]
// a byte that follows its transition holds the back part for the pop and row read, then the match
// an item that gives results holds it through match (and kind at most ends) unless stopped, then
// through output, one result at a time, waiting on stalls; table writes are done at the pop
// the row read and the priority match set the per-byte rate; the input queue holds two items
// synchronous active-low reset; afterwards the tables are cleared, one node a cycle,
// through all NODES nodes, during which queued items wait
module range_table_dfa_tokenizer #(
    parameter int NODES      = 64,
    parameter int SLOTS      = 8,
    parameter int MAX_LEXEME = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // repeat_at_end
    input  logic        s_tvalid,
    output logic        s_tready,
    // node, slot, range_low, range_high, target_node, entry_valid, accept_kind, char_in
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,      // action
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_kind, lexeme_length, line_count, column_count
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser,      // status
    output logic        m_tlast
);

    logic              rep_reg;
    logic              item_valid;
    logic              item_pop;
    rtdt_pkg::item_t   item;
    rtdt_pkg::result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_reg <= 1'b0;
        end else if (cfg_valid) begin
            rep_reg <= cfg_data;
        end
    end

    rtdt_front #(.NODES(NODES), .SLOTS(SLOTS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rtdt_back #(.NODES(NODES), .SLOTS(SLOTS), .MAX_LEXEME(MAX_LEXEME)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rep_in     (rep_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res),
        .res_last   (m_tlast)
    );

    assign m_tdata = {5'd0, res.col, res.line, res.len, res.kind};
    assign m_tuser = res.status;

endmodule

[test/tb_range_table_dfa_tokenizer.sv]
`timescale 1ns / 100ps

module tb_range_table_dfa_tokenizer;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 30;

    typedef struct {
        logic signed [10:0] kind;
        logic [7:0]         len;
        logic [15:0]        line;
        logic [15:0]        col;
        logic [1:0]         status;
        logic               last;
    } token_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // automaton copy held by the predictor
    logic signed [7:0]  edge_lo [512];
    logic signed [7:0]  edge_hi [512];
    logic [5:0]         edge_to [512];
    logic               edge_on [512];
    logic signed [10:0] node_kind [64];
    logic [5:0]         cur_node;
    logic [7:0]         lexeme_len;
    logic [15:0]        line_no;
    logic [15:0]        col_no;
    logic [1:0]         run_state;
    logic               repeat_mode;

    token_t token_q[$];
    int     errors;
    int     cycles;
    bit     quiet;

    range_table_dfa_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);

    function automatic bit find_edge(input logic [5:0] n, input logic signed [7:0] c,
                                     output logic [5:0] nxt);
        int i;
        nxt = 0;
        for (int s = 0; s < 8; s++) begin
            i = n * 8 + s;
            if (edge_on[i] && edge_lo[i] <= c && c <= edge_hi[i]) begin
                nxt = edge_to[i];
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void take_byte(input logic [5:0] nxt, input logic signed [7:0] c);
        cur_node = nxt;
        if (lexeme_len < 8'd255) lexeme_len++;
        if (c == rtdt_pkg::CHAR_NL) begin
            if (line_no != rtdt_pkg::CNT_MAX) line_no++;
            col_no = 1;
        end else if (col_no != rtdt_pkg::CNT_MAX) begin
            col_no++;
        end
    endfunction

    function automatic token_t make_token(input logic signed [10:0] k, input logic [7:0] l,
                                          input logic [1:0] st);
        token_t t;
        t.kind = k; t.len = l; t.line = line_no; t.col = col_no; t.status = st; t.last = 0;
        return t;
    endfunction

    function automatic bit close_lexeme(ref token_t outq[$]);
        logic signed [10:0] k;
        bit ok;
        k = node_kind[cur_node];
        ok = lexeme_len > 0 && k >= 0;
        if (ok) begin
            run_state = rtdt_pkg::STAT_VALID;
            outq = {outq, make_token(k, lexeme_len, rtdt_pkg::STAT_VALID)};
        end else begin
            run_state = rtdt_pkg::STAT_NONACC;
            outq = {outq, make_token(rtdt_pkg::KIND_NONE, lexeme_len, rtdt_pkg::STAT_NONACC)};
        end
        cur_node = 0;
        lexeme_len = 0;
        return ok;
    endfunction

    function automatic void predict_tokens(input logic [1:0] act, input logic [55:0] d);
        token_t outq[$];
        logic [5:0] nd, nxt;
        logic signed [7:0] lo, hi, c;
        bit had, ok;
        int i;
        nd = d[5:0];
        lo = d[16:9];
        hi = d[24:17];
        c = d[50:43];
        i = nd * 8 + d[8:6];
        if (act == rtdt_pkg::ACT_SLOT) begin
            edge_lo[i] = lo < hi ? lo : hi;
            edge_hi[i] = lo < hi ? hi : lo;
            edge_to[i] = d[30:25];
            edge_on[i] = d[31];
            return;
        end
        if (act == rtdt_pkg::ACT_KIND) begin
            node_kind[nd] = d[42:32];
            return;
        end
        if (!repeat_mode && run_state != rtdt_pkg::STAT_VALID) begin
            if (run_state != rtdt_pkg::STAT_ACCEND) run_state = rtdt_pkg::STAT_BAD;
            outq = {outq, make_token(rtdt_pkg::KIND_NONE, 0, run_state)};
        end else if (act == rtdt_pkg::ACT_BYTE) begin
            if (find_edge(cur_node, c, nxt)) begin
                take_byte(nxt, c);
            end else begin
                had = lexeme_len > 0;
                ok = close_lexeme(outq);
                if (had && (ok || repeat_mode)) begin
                    if (find_edge(0, c, nxt)) begin
                        take_byte(nxt, c);
                    end else begin
                        run_state = rtdt_pkg::STAT_NONACC;
                        outq = {outq, make_token(rtdt_pkg::KIND_NONE, 0,
                                                 rtdt_pkg::STAT_NONACC)};
                    end
                end
            end
        end else begin
            ok = 1;
            if (lexeme_len > 0) ok = close_lexeme(outq);
            if (ok || repeat_mode) begin
                cur_node = 0;
                if (find_edge(0, rtdt_pkg::CHAR_NUL, nxt)) begin
                    run_state = rtdt_pkg::STAT_ACCEND;
                    outq = {outq, make_token(node_kind[nxt], 0, rtdt_pkg::STAT_ACCEND)};
                end else begin
                    run_state = rtdt_pkg::STAT_NONACC;
                    outq = {outq, make_token(rtdt_pkg::KIND_NONE, 0, rtdt_pkg::STAT_NONACC)};
                end
            end
        end
        if (outq.size() > 0) outq[outq.size() - 1].last = 1;
        token_q = {token_q, outq};
    endfunction

    // result checker
    always @(posedge aclk) begin
        token_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%0d tlast=%0b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                e = token_q[0];
                token_q.delete(0);
                if (m_tdata[10:0] !== e.kind || m_tdata[18:11] !== e.len ||
                    m_tdata[34:19] !== e.line || m_tdata[50:35] !== e.col ||
                    m_tdata[55:51] !== 5'd0 || m_tuser !== e.status || m_tlast !== e.last) begin
                    $display("%0t: mismatch expected kind=%0d len=%0d line=%0d col=%0d",
                             $time, e.kind, e.len, e.line, e.col,
                             " st=%0d last=%0b", e.status, e.last);
                    $display("%0t:          actual kind=%0d len=%0d line=%0d col=%0d",
                             $time, $signed(m_tdata[10:0]), m_tdata[18:11], m_tdata[34:19],
                             m_tdata[50:35], " st=%0d last=%0b", m_tuser, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [5:0] nd, input logic [2:0] sl,
                             input logic signed [7:0] lo, input logic signed [7:0] hi,
                             input logic [5:0] tgt, input logic ev,
                             input logic signed [10:0] k, input logic signed [7:0] c);
        logic [55:0] d;
        d = {5'd0, c, k, ev, tgt, hi, lo, sl, nd};
        if (!quiet && $urandom_range(99) < 7) begin
            @(negedge aclk);
            s_tvalid <= 0;
            repeat ($urandom_range(4)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata <= d;
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        predict_tokens(act, d);
    endtask

    task automatic put_edge(input logic [5:0] nd, input logic [2:0] sl,
                            input logic signed [7:0] lo, input logic signed [7:0] hi,
                            input logic [5:0] tgt);
        send_item(rtdt_pkg::ACT_SLOT, nd, sl, lo, hi, tgt, 1'b1, 0, 0);
    endtask

    task automatic put_kind(input logic [5:0] nd, input logic signed [10:0] k);
        send_item(rtdt_pkg::ACT_KIND, nd, 0, 0, 0, 0, 0, k, 0);
    endtask

    task automatic feed(input logic signed [7:0] c);
        send_item(rtdt_pkg::ACT_BYTE, 0, 0, 0, 0, 0, 0, 0, c);
    endtask

    task automatic end_stream();
        send_item(rtdt_pkg::ACT_END, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_repeat(input logic v);
        drain();
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        repeat_mode = v;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // identifiers, numbers, newline, end marker and a gate into the random nodes
    task automatic test_table_load();
        put_edge(0, 0, "z", "a", 1);        // ends given swapped
        put_edge(0, 1, "0", "9", 2);
        put_edge(0, 2, 8'sh0A, 8'sh0A, 3);
        put_edge(0, 3, 0, 0, 4);
        put_edge(0, 7, -128, -100, 8);
        put_edge(1, 0, "a", "z", 1);
        put_edge(1, 1, "0", "9", 1);
        put_edge(2, 0, "0", "9", 2);
        // empty slot, never matches
        send_item(rtdt_pkg::ACT_SLOT, 2, 1, -128, 127, 5, 1'b0, 0, 0);
        put_edge(8, 0, -128, 127, 8);
        put_kind(1, 5);
        put_kind(2, 1023);
        put_kind(3, 9);
        put_kind(4, 0);
        put_kind(8, -1);
    endtask

    task automatic test_tokens();
        feed("a"); feed("b"); feed("1");
        feed(" ");                          // accepting lexeme then retry fails
        feed("7"); feed("x");               // stopped after the failed retry, bad stream
        feed(8'sh0A);
        feed(127);                          // bad stream
        feed(-128);
        end_stream();                       // the block is already stopped, bad stream
        feed("a");                          // bad stream
        end_stream();
    endtask

    task automatic test_repeat_mode();
        set_repeat(1);
        feed("q"); feed(127); feed("9"); end_stream(); end_stream();
        feed(" "); feed(-128); end_stream();
    endtask

    task automatic test_accept_end_stop();
        set_repeat(0);
        feed("k"); end_stream();            // accepted end, stays stopped
        feed("k"); end_stream();
    endtask

    task automatic random_items(input int count);
        int r, run;
        for (int n = 0; n < count; n++) begin
            quiet = (n % 400) >= 300;
            r = $urandom_range(99);
            if (r < 4) begin
                send_item(rtdt_pkg::ACT_SLOT, 6'($urandom_range(8, 63)), 3'($urandom),
                          8'($urandom), 8'($urandom), 6'($urandom), 1'($urandom),
                          11'($urandom), 8'($urandom));
            end else if (r < 7) begin
                send_item(rtdt_pkg::ACT_KIND, 6'($urandom_range(5, 63)), 3'($urandom),
                          8'($urandom), 8'($urandom), 6'($urandom), 1'($urandom),
                          11'(int'($urandom_range(0, 1024)) - 1), 8'($urandom));
            end else if (r < 12) begin
                end_stream();
            end else if (r < 14) begin
                run = $urandom_range(200, 300);     // long identifier, length can saturate
                for (int j = 0; j < run; j++) feed(8'($urandom_range("a", "z")));
                n += run;
            end else if (r < 55) begin
                feed(8'($urandom_range("a", "z")));
            end else if (r < 75) begin
                feed(8'($urandom_range("0", "9")));
            end else if (r < 83) begin
                feed(" ");
            end else if (r < 88) begin
                feed(8'sh0A);
            end else begin
                feed(8'($urandom));
            end
        end
        quiet = 0;
    endtask

    task automatic test_random();
        set_repeat(1);
        random_items(1100);
        set_repeat(0);
        random_items(300);
    endtask

    initial begin
        for (int i = 0; i < 512; i++) begin
            edge_lo[i] = 0; edge_hi[i] = 0; edge_to[i] = 0; edge_on[i] = 0;
        end
        for (int i = 0; i < 64; i++) node_kind[i] = rtdt_pkg::KIND_NONE;
        cur_node = 0; lexeme_len = 0; line_no = 1; col_no = 1;
        run_state = rtdt_pkg::STAT_VALID; repeat_mode = 0;
        errors = 0; cycles = 0; quiet = 0;
        aresetn = 0;
        cfg_valid = 0; cfg_data = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        m_tready = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        test_table_load();
        test_tokens();
        test_repeat_mode();
        test_accept_end_stop();
        test_random();

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
